// File: design/lkvc_pkg.sv
// Shared types and constants of the LRU key-value cache.
// Holds the search token and update command that pass between the top level and its cells.
// Depends on nothing; every other design file uses it.
package lkvc_pkg;

  localparam int KEY_W     = 16;
  localparam int VALUE_W   = 32;
  localparam int CAP_W     = 5;
  // Slot indexes and ranks travel at this width so that up to 256 slots fit.
  localparam int IDX_MAX_W = 8;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef logic [IDX_MAX_W-1:0] wide_idx_t;

  // Token that walks down the row of cells, one cell per cycle, gathering
  // what the update needs.
  typedef struct packed {
    logic                      live;
    logic                      hit;
    wide_idx_t                 hit_idx;
    wide_idx_t                 hit_rank;
    logic signed [VALUE_W-1:0] hit_value;
    logic                      free;
    wide_idx_t                 free_idx;
    logic                      victim;
    wide_idx_t                 victim_idx;
  } lkvc_tok_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic                      apply;
    logic                      touch;
    logic                      write;
    logic                      insert;
    logic                      evict;
    wide_idx_t                 touch_idx;
    wide_idx_t                 touch_rank;
    wide_idx_t                 ins_idx;
    wide_idx_t                 vic_idx;
    wide_idx_t                 oldest;
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
  } lkvc_cmd_t;

endpackage

// File: design/lkvc_if.sv
// Handshake channels of the LRU key-value cache: request, response and configuration.
// Depends on lkvc_pkg for the field widths.
interface lkvc_req_if;
  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic [lkvc_pkg::KEY_W-1:0]         lookup_key;
  logic signed [lkvc_pkg::VALUE_W-1:0] write_value;

  modport source (output valid, output operation, output lookup_key, output write_value,
                  input ready);
  modport sink   (input valid, input operation, input lookup_key, input write_value,
                  output ready);
endinterface

interface lkvc_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               hit;
  logic signed [lkvc_pkg::VALUE_W-1:0] read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface

interface lkvc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lkvc_pkg::CAP_W-1:0] capacity_in_use;

  modport source (output valid, output capacity_in_use, input ready);
  modport sink   (input valid, input capacity_in_use, output ready);
endinterface

// File: design/lkvc_cell.sv
// One slot of the LRU key-value cache: key, value, valid bit and recency rank.
// Examines the passing search token and applies the broadcast update command.
// Depends on lkvc_pkg.
module lkvc_cell #(
  parameter int KEY_W   = 16,
  parameter int RANK_W  = 4,
  parameter int CELL_ID = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  lkvc_pkg::lkvc_tok_t tok_in,
  output lkvc_pkg::lkvc_tok_t tok_out,
  input  lkvc_pkg::lkvc_cmd_t cmd
);

  localparam lkvc_pkg::wide_idx_t ID = CELL_ID[lkvc_pkg::IDX_MAX_W-1:0];

  logic                                slot_valid;
  logic [KEY_W-1:0]                    slot_key;
  logic signed [lkvc_pkg::VALUE_W-1:0] slot_value;
  logic [RANK_W-1:0]                   slot_rank;

  lkvc_pkg::wide_idx_t rank_ext;
  logic                key_hit;
  logic                is_touch;
  logic                is_ins;
  logic                is_vic;
  lkvc_pkg::lkvc_tok_t tok_next;

  assign rank_ext = lkvc_pkg::wide_idx_t'(slot_rank);
  assign key_hit  = slot_valid && (slot_key == cmd.key[KEY_W-1:0]);
  assign is_touch = (cmd.touch_idx == ID);
  assign is_ins   = (cmd.ins_idx == ID);
  assign is_vic   = (cmd.vic_idx == ID);

  // The last matching slot wins, the first free slot wins.
  always_comb begin
    tok_next = tok_in;
    if (key_hit) begin
      tok_next.hit       = 1'b1;
      tok_next.hit_idx   = ID;
      tok_next.hit_rank  = rank_ext;
      tok_next.hit_value = slot_value;
    end
    if (!slot_valid && !tok_in.free) begin
      tok_next.free     = 1'b1;
      tok_next.free_idx = ID;
    end
    if (slot_valid && (rank_ext == cmd.oldest)) begin
      tok_next.victim     = 1'b1;
      tok_next.victim_idx = ID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.live <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (cmd.apply && cmd.insert) begin
      if (is_ins) begin
        slot_valid <= 1'b1;
      end else if (cmd.evict && is_vic) begin
        slot_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (cmd.touch) begin
        if (is_touch) begin
          slot_rank <= '0;
          if (cmd.write) begin
            slot_value <= cmd.value;
          end
        end else if (slot_valid && (rank_ext < cmd.touch_rank)) begin
          slot_rank <= RANK_W'(slot_rank + 1'b1);
        end
      end else if (cmd.insert) begin
        if (is_ins) begin
          slot_key   <= cmd.key[KEY_W-1:0];
          slot_value <= cmd.value;
          slot_rank  <= '0;
        end else if (slot_valid && !(cmd.evict && is_vic)) begin
          slot_rank <= RANK_W'(slot_rank + 1'b1);
        end
      end
    end
  end

endmodule

// File: design/lru_key_value_cache.sv
// Top level of the LRU key-value cache: controller, result register and the row of slot cells.
// Depends on lkvc_pkg, the channel interfaces in lkvc_if and lkvc_cell.
//
// Usage. The req channel carries one word per operation: operation (get or put), lookup_key
// and write_value. The rsp channel returns exactly one word per request: hit, set when the
// key was present before the operation, and read_value, the stored value on a get that hits
// and zero otherwise. The cfg channel writes capacity_in_use, the number of entries held
// before the least recent one is evicted; zero acts as one and values above ENTRIES act as
// ENTRIES. cfg is always ready and is meant to be written while no request is in flight.
//
// Timing. A request is served by a search token that walks the row of ENTRIES cells, one
// cell per cycle, collecting the hit, the first free slot and the least recent slot. The
// token is then latched into the tail register, and in the done state the update is applied
// to all cells at once while the response is loaded. The next request can be accepted once
// the response becomes valid; a request is not accepted while another is in flight.
//
// The response sits in an output register: a new request is accepted while a finished
// response waits, and only the commit of that next result waits for rsp.ready.
// Reset (rst, synchronous) empties the cache, drops any pending response and sets the
// capacity back to 16.
module lru_key_value_cache #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  lkvc_req_if.sink   req,
  lkvc_rsp_if.source rsp,
  lkvc_cfg_if.sink   cfg
);

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int SK_W   = (KEY_BITS < lkvc_pkg::KEY_W) ? KEY_BITS : lkvc_pkg::KEY_W;
  localparam int CMP_W  = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;

  logic [1:0]                          state;
  logic [1:0]                          state_next;
  logic                                seed_live;
  logic                                q_op;
  logic [SK_W-1:0]                     q_key;
  logic signed [lkvc_pkg::VALUE_W-1:0] q_value;
  lkvc_pkg::lkvc_tok_t                 tail;
  logic [CNT_W-1:0]                    fill_count;
  logic [lkvc_pkg::CAP_W-1:0]          capacity;
  logic                                out_valid;
  logic                                out_hit;
  logic signed [lkvc_pkg::VALUE_W-1:0] out_value;

  lkvc_pkg::lkvc_tok_t chain [ENTRIES+1];
  lkvc_pkg::lkvc_cmd_t cmd;

  logic             accept;
  logic             done_fire;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;
  logic             full;
  logic             need_evict;
  lkvc_pkg::wide_idx_t ins_idx;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign done_fire = (state == ST_DONE) && (!out_valid || rsp.ready);
  assign cfg.ready = 1'b1;

  assign rsp.valid      = out_valid;
  assign rsp.hit        = out_hit;
  assign rsp.read_value = out_value;

  // Effective capacity, clamped to the range one to ENTRIES.
  assign cap_ext = CMP_W'(capacity);
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full       = (CMP_W'(fill_count) >= eff_cap);
  assign need_evict = full || !tail.free;

  // After an eviction the lowest invalid slot is either the old first free slot or the
  // victim, whichever is lower.
  always_comb begin
    if (!tail.free) begin
      ins_idx = tail.victim_idx;
    end else if (need_evict && (tail.victim_idx < tail.free_idx)) begin
      ins_idx = tail.victim_idx;
    end else begin
      ins_idx = tail.free_idx;
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.apply      = done_fire;
    cmd.touch      = tail.hit;
    cmd.write      = (q_op == lkvc_pkg::OP_PUT);
    cmd.insert     = (q_op == lkvc_pkg::OP_PUT) && !tail.hit;
    cmd.evict      = need_evict;
    cmd.touch_idx  = tail.hit_idx;
    cmd.touch_rank = tail.hit_rank;
    cmd.ins_idx    = ins_idx;
    cmd.vic_idx    = tail.victim_idx;
    cmd.oldest     = lkvc_pkg::wide_idx_t'(fill_count - 1'b1);
    cmd.key        = lkvc_pkg::KEY_W'(q_key);
    cmd.value      = q_value;
  end

  // The token enters the first cell with all flags clear.
  always_comb begin
    chain[0]      = '0;
    chain[0].live = seed_live;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkvc_cell #(
      .KEY_W   (SK_W),
      .RANK_W  (RANK_W),
      .CELL_ID (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1]),
      .cmd     (cmd)
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (chain[ENTRIES].live) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (done_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      seed_live  <= 1'b0;
      fill_count <= '0;
      capacity   <= lkvc_pkg::CAP_W'(16);
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      seed_live <= accept;
      if (cfg.valid && cfg.ready) begin
        capacity <= cfg.capacity_in_use;
      end
      if (done_fire && cmd.insert && !need_evict) begin
        fill_count <= CNT_W'(fill_count + 1'b1);
      end
      if (done_fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_op    <= req.operation;
      q_key   <= req.lookup_key[SK_W-1:0];
      q_value <= req.write_value;
    end
    if ((state == ST_SEARCH) && chain[ENTRIES].live) begin
      tail <= chain[ENTRIES];
    end
    if (done_fire) begin
      out_hit <= tail.hit;
      if ((q_op == lkvc_pkg::OP_GET) && tail.hit) begin
        out_value <= tail.hit_value;
      end else begin
        out_value <= '0;
      end
    end
  end

endmodule

// File: design/lkvc_checker.sv
// Port-level checks of the LRU key-value cache, attached to the top level by bind.
// Depends on lkvc_pkg and on the top level lru_key_value_cache.
module lkvc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_hit,
  input logic signed [lkvc_pkg::VALUE_W-1:0] out_value
);

  // Only one request is in flight: ready drops right after a word is taken.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // A response never appears in the cycle after a request was accepted.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("response produced too early");

  // A miss never returns a value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_hit |-> out_value == '0)
    else $error("nonzero read value on a miss");

  // A stalled response holds its word.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_hit))
    else $error("stalled response changed");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_hit   (rsp.hit),
  .out_value (rsp.read_value)
);
